>>> hdl/hds_pkg.sv
// Package for the hemisphere direction sampler: beat types, cell state types,
// fixed-point constants and the sine series coefficients. No dependencies.
package hds_pkg;

	localparam logic MODE_UNIFORM = 1'b0;
	localparam logic MODE_COSINE  = 1'b1;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	// Square root cells: a 34-bit radicand gives a 17-bit root, one bit per cell.
	localparam int SQ_STEPS  = 17;
	localparam int SQ_RAD_W  = 34;
	localparam int SQ_REM_W  = 19;
	localparam int SQ_ROOT_W = 17;

	// Horner cells of the quarter-wave sine series, Q2.30.
	localparam int SIN_CELLS = 4;
	localparam logic [30:0] SIN_C9 = 31'd172271;
	localparam logic [30:0] SIN_COEF [SIN_CELLS] = '{
		31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
	};
	localparam logic [14:0] QUARTER = 15'd16384;

	typedef struct packed {
		logic signed [15:0] t0_x;
		logic signed [15:0] t0_y;
		logic signed [15:0] t0_z;
		logic signed [15:0] n_x;
		logic signed [15:0] n_y;
		logic signed [15:0] n_z;
		logic signed [15:0] t1_x;
		logic signed [15:0] t1_y;
		logic signed [15:0] t1_z;
	} frame_t;

	typedef struct packed {
		logic               mode;
		logic        [15:0] u;
		logic        [15:0] v;
		logic signed [15:0] t0_x;
		logic signed [15:0] t0_y;
		logic signed [15:0] t0_z;
		logic signed [15:0] n_x;
		logic signed [15:0] n_y;
		logic signed [15:0] n_z;
		logic signed [15:0] t1_x;
		logic signed [15:0] t1_y;
		logic signed [15:0] t1_z;
	} smp_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} dir_t;

	typedef struct packed {
		logic [SQ_RAD_W-1:0]  rad;
		logic [SQ_REM_W-1:0]  rem;
		logic [SQ_ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [14:0] f;
		logic [30:0] x2;
		logic [30:0] acc;
	} trig_t;

	typedef struct packed {
		logic [15:0] h;
		logic [15:0] u;
		frame_t      fr;
	} side_b_t;

endpackage

>>> hdl/hds_sqrt_cell.sv
// One digit step of a floor integer square root, registered.
// Depends on hds_pkg.
module hds_sqrt_cell (
	input  logic          clk,
	input  logic          en,
	input  hds_pkg::sq_t  d,
	output hds_pkg::sq_t  q
);
	import hds_pkg::*;

	logic [SQ_REM_W+1:0] cur;
	logic [SQ_REM_W+1:0] trial;
	logic [SQ_REM_W+1:0] diff;
	sq_t                 nxt;

	always_comb begin
		cur   = {d.rem, d.rad[SQ_RAD_W-1 -: 2]};
		trial = {2'b00, d.root, 2'b01};
		diff  = cur - trial;
		nxt.rad = {d.rad[SQ_RAD_W-3:0], 2'b00};
		if (cur >= trial) begin
			nxt.rem  = diff[SQ_REM_W-1:0];
			nxt.root = {d.root[SQ_ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = cur[SQ_REM_W-1:0];
			nxt.root = {d.root[SQ_ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

>>> hdl/hds_sine_cell.sv
// One Horner step of the quarter-wave sine series: acc = coef - x2*acc, Q2.30.
// Depends on hds_pkg.
module hds_sine_cell (
	input  logic           clk,
	input  logic           en,
	input  logic [30:0]    coef,
	input  hds_pkg::trig_t d,
	output hds_pkg::trig_t q
);
	import hds_pkg::*;

	logic [61:0] prod;
	logic [31:0] diff;

	always_comb begin
		prod = 62'(d.x2) * 62'(d.acc);
		diff = {1'b0, coef} - prod[61:30];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q.f   <= d.f;
			q.x2  <= d.x2;
			q.acc <= diff[30:0];
		end
	end

endmodule

>>> hdl/hemisphere_direction_sampler.sv
// Top level of the hemisphere direction sampler: input register, two chains of
// square root cells, a chain of sine cells, frame transform and output register.
// Depends on hds_pkg, hds_sqrt_cell and hds_sine_cell.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------
//   sample   | smp_valid, smp_ready  | smp  (mode, u, v, frame)
//   result   | dir_valid, dir_ready  | dir  (dir_x, dir_y, dir_z)
//
// One beat is taken every cycle unless stalled; results leave through the
// output register. The two 17-cell square root chains run in series (height,
// then radius), the trig stages beside the radius chain, then scale and product.
// Reset clears only the valid bits of the stages and of the output register.
// The whole pipeline stalls only while the output register holds an unread
// result and the last stage holds a live item; bubbles inside the pipeline
// move along with it and are not squeezed out.
module hemisphere_direction_sampler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          smp_valid,
	output logic          smp_ready,
	input  hds_pkg::smp_t smp,
	output logic          dir_valid,
	input  logic          dir_ready,
	output hds_pkg::dir_t dir
);
	import hds_pkg::*;

	// Stage 1 is the input register, stages 2..18 the height root chain,
	// stage 19 squares the height, stages 20..36 the radius root chain with
	// the sine chain running alongside in its last six stages, stage 37 forms
	// the local vector and stage 38 the nine frame products.
	localparam int NST      = 38;
	localparam int TRIG_TAP = SQ_STEPS - 7;

	logic [NST:1] vld_q;
	logic         out_valid_q;
	dir_t         out_q;
	logic         out_load;
	logic         en;

	assign out_load  = !out_valid_q || dir_ready;
	assign en        = out_load || !vld_q[NST];
	assign smp_ready = en;
	assign dir_valid = out_valid_q;
	assign dir       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[NST-1:1], smp_valid};
			end
			if (out_load) begin
				out_valid_q <= vld_q[NST];
			end
		end
	end

	// Input register.
	smp_t in_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= smp;
		end
	end

	// Height chain: isqrt(v * 2^16), used only in cosine mode.
	sq_t  sq_a_q [SQ_STEPS];
	smp_t sb_a_q [SQ_STEPS];
	sq_t  sq_a_in;

	assign sq_a_in = '{rad: {2'b00, in_s1.v, 16'h0000}, rem: '0, root: '0};

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq_a
		if (k == 0) begin : g_first
			hds_sqrt_cell u_cell (.clk(clk), .en(en), .d(sq_a_in), .q(sq_a_q[k]));
			always_ff @(posedge clk) begin
				if (en) begin
					sb_a_q[k] <= in_s1;
				end
			end
		end else begin : g_rest
			hds_sqrt_cell u_cell (.clk(clk), .en(en), .d(sq_a_q[k-1]), .q(sq_a_q[k]));
			always_ff @(posedge clk) begin
				if (en) begin
					sb_a_q[k] <= sb_a_q[k-1];
				end
			end
		end
	end

	// Height select and square.
	logic [15:0] hsel;
	logic [15:0] h_s19;
	logic [31:0] hh_s19;
	logic [15:0] u_s19;
	frame_t      fr_s19;

	assign hsel = (sb_a_q[SQ_STEPS-1].mode == MODE_COSINE) ?
		sq_a_q[SQ_STEPS-1].root[15:0] : sb_a_q[SQ_STEPS-1].v;

	always_ff @(posedge clk) begin
		if (en) begin
			h_s19  <= hsel;
			hh_s19 <= 32'(hsel) * 32'(hsel);
			u_s19  <= sb_a_q[SQ_STEPS-1].u;
			fr_s19 <= frame_t'(sb_a_q[SQ_STEPS-1][143:0]);
		end
	end

	// Radius chain: isqrt(2^32 - h*h).
	sq_t     sq_b_q [SQ_STEPS];
	side_b_t sb_b_q [SQ_STEPS];
	sq_t     sq_b_in;

	assign sq_b_in = '{rad: 34'd4294967296 - {2'b00, hh_s19}, rem: '0, root: '0};

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq_b
		if (k == 0) begin : g_first
			hds_sqrt_cell u_cell (.clk(clk), .en(en), .d(sq_b_in), .q(sq_b_q[k]));
			always_ff @(posedge clk) begin
				if (en) begin
					sb_b_q[k] <= '{h: h_s19, u: u_s19, fr: fr_s19};
				end
			end
		end else begin : g_rest
			hds_sqrt_cell u_cell (.clk(clk), .en(en), .d(sq_b_q[k-1]), .q(sq_b_q[k]));
			always_ff @(posedge clk) begin
				if (en) begin
					sb_b_q[k] <= sb_b_q[k-1];
				end
			end
		end
	end

	// Sine chain, two lanes: sine of f and sine of the complement (cosine).
	trig_t       tr_s_q [SIN_CELLS+1];
	trig_t       tr_c_q [SIN_CELLS+1];
	logic [14:0] f_sin;
	logic [14:0] f_cos;
	logic [29:0] ff_sin;
	logic [29:0] ff_cos;

	always_comb begin
		f_sin  = {1'b0, sb_b_q[TRIG_TAP].u[13:0]};
		f_cos  = QUARTER - f_sin;
		ff_sin = 30'(f_sin) * 30'(f_sin);
		ff_cos = 30'(f_cos) * 30'(f_cos);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tr_s_q[0] <= '{f: f_sin, x2: {ff_sin[28:0], 2'b00}, acc: SIN_C9};
			tr_c_q[0] <= '{f: f_cos, x2: {ff_cos[28:0], 2'b00}, acc: SIN_C9};
		end
	end

	for (genvar j = 0; j < SIN_CELLS; j++) begin : g_sin
		hds_sine_cell u_sin (
			.clk(clk), .en(en), .coef(SIN_COEF[j]), .d(tr_s_q[j]), .q(tr_s_q[j+1])
		);
		hds_sine_cell u_cos (
			.clk(clk), .en(en), .coef(SIN_COEF[j]), .d(tr_c_q[j]), .q(tr_c_q[j+1])
		);
	end

	// Final odd-power multiply, lands with the last radius cell.
	logic [45:0] fin_sin;
	logic [45:0] fin_cos;
	logic [30:0] sin_mag_s36;
	logic [30:0] cos_mag_s36;

	always_comb begin
		fin_sin = 46'(tr_s_q[SIN_CELLS].f) * 46'(tr_s_q[SIN_CELLS].acc);
		fin_cos = 46'(tr_c_q[SIN_CELLS].f) * 46'(tr_c_q[SIN_CELLS].acc);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_mag_s36 <= fin_sin[44:14];
			cos_mag_s36 <= fin_cos[44:14];
		end
	end

	// Local vector: quadrant folding and scaling by the radius.
	side_b_t     sb_last;
	logic [16:0] r_last;
	logic [30:0] cmag;
	logic [30:0] smag;
	logic        cneg;
	logic        sneg;
	logic [47:0] px;
	logic [47:0] pz;
	logic signed [31:0] lv_s37 [3];
	frame_t      fr_s37;

	assign sb_last = sb_b_q[SQ_STEPS-1];
	assign r_last  = sq_b_q[SQ_STEPS-1].root;

	always_comb begin
		case (sb_last.u[15:14])
			QUAD_0: begin
				cmag = cos_mag_s36; cneg = 1'b0; smag = sin_mag_s36; sneg = 1'b0;
			end
			QUAD_1: begin
				cmag = sin_mag_s36; cneg = 1'b1; smag = cos_mag_s36; sneg = 1'b0;
			end
			QUAD_2: begin
				cmag = cos_mag_s36; cneg = 1'b1; smag = sin_mag_s36; sneg = 1'b1;
			end
			default: begin
				cmag = sin_mag_s36; cneg = 1'b0; smag = cos_mag_s36; sneg = 1'b1;
			end
		endcase
		px = 48'(r_last) * 48'(cmag);
		pz = 48'(r_last) * 48'(smag);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lv_s37[0] <= cneg ? -$signed({1'b0, px[46:16]}) : $signed({1'b0, px[46:16]});
			lv_s37[1] <= $signed({2'b00, sb_last.h, 14'h0000});
			lv_s37[2] <= sneg ? -$signed({1'b0, pz[46:16]}) : $signed({1'b0, pz[46:16]});
			fr_s37    <= sb_last.fr;
		end
	end

	// Frame products: term j (tangent0, normal, tangent1) of component k.
	logic signed [15:0] fv [9];
	logic signed [47:0] prod_s38 [3][3];

	always_comb begin
		fv[0] = fr_s37.t0_x; fv[1] = fr_s37.t0_y; fv[2] = fr_s37.t0_z;
		fv[3] = fr_s37.n_x;  fv[4] = fr_s37.n_y;  fv[5] = fr_s37.n_z;
		fv[6] = fr_s37.t1_x; fv[7] = fr_s37.t1_y; fv[8] = fr_s37.t1_z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s38[k][j] <= 48'(lv_s37[j]) * 48'(fv[3*j+k]);
				end
			end
		end
	end

	// Sum, round half up and saturate to Q2.14.
	logic signed [50:0] rsum [3];
	logic signed [20:0] qv   [3];
	logic signed [15:0] sat  [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rsum[k] = 51'(prod_s38[k][0]) + 51'(prod_s38[k][1]) + 51'(prod_s38[k][2])
				+ 51'sd536870912;
			qv[k] = rsum[k][50:30];
			if (qv[k] > 21'sd32767) begin
				sat[k] = 16'sd32767;
			end else if (qv[k] < -21'sd32768) begin
				sat[k] = -16'sd32768;
			end else begin
				sat[k] = qv[k][15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= '{dir_x: sat[0], dir_y: sat[1], dir_z: sat[2]};
		end
	end

	// An accepted beat occupies the first stage on the next cycle.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready |=> vld_q[1])
		else $error("accepted beat did not enter the pipeline");

	// The input side is held off only by an unread result with a live item behind it.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!smp_ready |-> out_valid_q && !dir_ready && vld_q[NST])
		else $error("input stalled without a blocked output");

	// While stalled, no item moves or disappears inside the pipeline.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valid bits changed during a stall");

	// A live last stage reaches the output register whenever it is free.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && vld_q[NST] |=> out_valid_q)
		else $error("result from the last stage was lost");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for hemisphere_direction_sampler: drives sample beats,
// predicts each direction in fixed point and checks the result beats in order.
// Depends on hds_pkg and the sampler RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hds_pkg::*;

	// Holds the predicted directions in beat order and counts mismatches.
	class direction_scoreboard;
		dir_t pending_dirs[$];
		int   mismatches;
		int   checked;

		// Sine of a quarter-turn fraction f/2^14 as Q2.30, truncated Horner series.
		static function longint unsigned quarter_sine(longint unsigned f);
			longint unsigned x2, acc;
			x2 = (f * f) << 2;
			acc = 64'd172271;
			acc = 64'd5026995 - ((x2 * acc) >> 30);
			acc = 64'd85569306 - ((x2 * acc) >> 30);
			acc = 64'd693598668 - ((x2 * acc) >> 30);
			acc = 64'd1686629713 - ((x2 * acc) >> 30);
			return (f * acc) >> 14;
		endfunction

		static function longint unsigned floor_sqrt(longint unsigned n);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > n)
				bitv >>= 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		// Round a Q4.44 sum to nearest Q2.14 (ties up) and saturate.
		static function logic signed [15:0] round_sat(longint s);
			longint t, q;
			t = s + 64'sd536870912;
			q = t >>> 30;
			if (q > 32767)
				q = 32767;
			if (q < -32768)
				q = -32768;
			return q[15:0];
		endfunction

		static function dir_t predict_direction(smp_t s);
			longint unsigned f, sv, cv, cmag, smag, h, r, vv;
			bit    cneg, sneg;
			longint lx, ly, lz;
			dir_t  d;
			f = s.u[13:0];
			sv = quarter_sine(f);
			cv = quarter_sine(64'd16384 - f);
			case (s.u[15:14])
				QUAD_0: begin cmag = cv; cneg = 0; smag = sv; sneg = 0; end
				QUAD_1: begin cmag = sv; cneg = 1; smag = cv; sneg = 0; end
				QUAD_2: begin cmag = cv; cneg = 1; smag = sv; sneg = 1; end
				default: begin cmag = sv; cneg = 0; smag = cv; sneg = 1; end
			endcase
			vv = s.v;
			if (s.mode == MODE_UNIFORM) begin
				h = vv;
				r = floor_sqrt((64'd1 << 32) - vv * vv);
			end else begin
				h = floor_sqrt(vv << 16);
				r = floor_sqrt((64'd1 << 32) - h * h);
			end
			lx = longint'((r * cmag) >> 16);
			lz = longint'((r * smag) >> 16);
			if (cneg)
				lx = -lx;
			if (sneg)
				lz = -lz;
			ly = longint'(h << 14);
			d.dir_x = round_sat(lx * longint'(s.t0_x) + ly * longint'(s.n_x)
				+ lz * longint'(s.t1_x));
			d.dir_y = round_sat(lx * longint'(s.t0_y) + ly * longint'(s.n_y)
				+ lz * longint'(s.t1_y));
			d.dir_z = round_sat(lx * longint'(s.t0_z) + ly * longint'(s.n_z)
				+ lz * longint'(s.t1_z));
			return d;
		endfunction

		function void note_sample(smp_t s);
			pending_dirs = {pending_dirs, predict_direction(s)};
		endfunction

		function void check_direction(dir_t got);
			dir_t want;
			if (pending_dirs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat x=%0d y=%0d z=%0d",
						got.dir_x, got.dir_y, got.dir_z);
				return;
			end
			want = pending_dirs.pop_front();
			checked++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
						checked, want.dir_x, want.dir_y, want.dir_z,
						got.dir_x, got.dir_y, got.dir_z);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic smp_valid;
	logic smp_ready;
	smp_t smp;
	logic dir_valid;
	logic dir_ready;
	dir_t dir;

	direction_scoreboard board;
	int  beats_sent;
	// While set, the receiver process holds dir_ready low for a long stretch.
	bit  hold_request;
	bit  hold_done;

	hemisphere_direction_sampler uut (
		.clk(clk), .arst_n(arst_n),
		.smp_valid(smp_valid), .smp_ready(smp_ready), .smp(smp),
		.dir_valid(dir_valid), .dir_ready(dir_ready), .dir(dir)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Scoreboard hooks sample the handshakes at each rising edge. The testbench
	// drives everything with nonblocking assignments, so values seen here are
	// the ones the design sees at this edge.
	always @(posedge clk) begin
		if (arst_n && smp_valid && smp_ready)
			board.note_sample(smp);
		if (arst_n && dir_valid && dir_ready)
			board.check_direction(dir);
	end

	// Receiver: a stall pattern of its own, with stretches of full readiness,
	// plus one long hold-off on request so that the pipeline backs up.
	initial begin : receiver
		int phase, k;
		dir_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				dir_ready <= 1'b0;
				for (k = 0; k < 120; k++)
					@(posedge clk);
				hold_done = 1'b1;
			end
			phase = (phase + 1) % 256;
			if (phase < 64)
				dir_ready <= 1'b1;
			else if (phase < 160)
				dir_ready <= ($urandom_range(0, 3) != 0);
			else
				dir_ready <= ($urandom_range(0, 1) != 0);
		end
	end

	// Offer one sample beat and wait for it to be accepted. Valid is left high;
	// the caller lowers it only when a gap follows.
	task automatic send_sample(smp_t s);
		smp_valid <= 1'b1;
		smp <= s;
		do
			@(posedge clk);
		while (!smp_ready);
		beats_sent++;
	endtask

	task automatic idle_gap(int cycles);
		if (cycles > 0) begin
			smp_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	function automatic smp_t random_sample();
		smp_t s;
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		s = raw[$bits(smp_t)-1:0];
		// Half the frames are unit-length style so outputs stay in range; the other half
		// are raw random frames that drive the sums into saturation.
		case ($urandom_range(0, 3))
			0: begin
				s.t0_x = 16'sd16384; s.t0_y = '0; s.t0_z = '0;
				s.n_x = '0; s.n_y = 16'sd16384; s.n_z = '0;
				s.t1_x = '0; s.t1_y = '0; s.t1_z = 16'sd16384;
			end
			1: begin
				s.t0_x = 16'($urandom_range(0, 16384));
				s.t0_y = 16'(-$urandom_range(0, 16384));
				s.n_x = 16'(-$urandom_range(0, 16384));
				s.n_z = 16'($urandom_range(0, 16384));
				s.t1_y = 16'($urandom_range(0, 16384));
				s.t1_z = 16'(-$urandom_range(0, 16384));
				s.t0_z = '0; s.n_y = 16'($urandom_range(0, 8192)); s.t1_x = '0;
			end
			default: ;
		endcase
		return s;
	endfunction

	initial begin : stimulus
		smp_t s;
		int   i, burst;
		board = new();
		arst_n <= 1'b0;
		smp_valid <= 1'b0;
		smp <= '0;
		hold_request = 1'b0;
		hold_done = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, both modes, every quadrant boundary,
		// a degenerate frame and full-scale frames that saturate.
		for (i = 0; i < 24; i++) begin
			s = '0;
			s.mode = i[0] ? MODE_COSINE : MODE_UNIFORM;
			s.u = (i < 10) ? 16'(i / 2 * 16384) : ((i < 14) ? 16'hFFFF : 16'h2000);
			s.v = (i % 4 < 2) ? 16'h0000 : 16'hFFFF;
			if (i < 18) begin
				s.t0_x = 16'sd16384; s.n_y = 16'sd16384; s.t1_z = 16'sd16384;
			end else if (i < 20) begin
				s.t0_x = 16'sh7FFF; s.t0_y = 16'sh8000; s.n_x = 16'sh7FFF;
				s.n_y = 16'sh8000; s.t1_x = 16'sh7FFF; s.t1_y = 16'sh8000;
				s.t0_z = 16'sh8000; s.n_z = 16'sh7FFF; s.t1_z = 16'sh8000;
				s.v = 16'h8000;
			end else if (i < 22) begin
				s.t0_x = 16'sh8000; s.n_x = 16'sh8000; s.t1_x = 16'sh8000;
				s.t0_y = 16'sh7FFF; s.n_y = 16'sh7FFF; s.t1_y = 16'sh7FFF;
				s.t0_z = 16'hFFFF; s.n_z = 16'hFFFF; s.t1_z = 16'hFFFF;
			end
			send_sample(s);
		end
		idle_gap(1);

		// Random part: bursts with random gaps, one long receiver hold-off while
		// the sender keeps offering, and one or more pauses until everything drained.
		while (beats_sent < 1700) begin
			burst = $urandom_range(1, 40);
			for (i = 0; i < burst; i++)
				send_sample(random_sample());
			if (beats_sent > 400 && !hold_request)
				hold_request = 1'b1;
			if (beats_sent > 900 && beats_sent < 960) begin
				smp_valid <= 1'b0;
				while (board.pending_dirs.size() != 0)
					@(posedge clk);
			end
			idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
		end
		smp_valid <= 1'b0;

		while (board.pending_dirs.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("Sent %0d sample beats in both modes across all quadrants,",
			beats_sent);
		$display("checked %0d directions; frames ranged from identity to saturating.",
			board.checked);
		if (board.mismatches == 0 && board.pending_dirs.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin : watchdog
		#5ms;
		$display("tb_top failed");
		$finish;
	end

endmodule
